// ===== design/extended_gcd_top_assert.svh =====
// assertion macros used by the checker file
`ifndef EXTENDED_GCD_TOP_ASSERT_SVH
`define EXTENDED_GCD_TOP_ASSERT_SVH
// implication checked on every edge out of reset
`define EG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked out of reset
`define EG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// shared constants and types for the extended gcd block
// ----------------------------------------------------------------------------
package egcd_pkg;
    localparam int DATA_WIDTH = 64;
    localparam int OPER_WIDTH = DATA_WIDTH - 1;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH + 1);
    localparam int IN_BYTES   = (2 * OPER_WIDTH + 7) / 8;
    localparam int OUT_BYTES  = (OPER_WIDTH + 2 * DATA_WIDTH + 7) / 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MULX,
        ST_MULY,
        ST_DONE
    } egcd_state_t;
endpackage

// ===== design/egcd_div.sv =====
// ----------------------------------------------------------------------------
// egcd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module egcd_div
    import egcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [OPER_WIDTH-1:0] dividend,
    input  logic [OPER_WIDTH-1:0] divisor_in,
    output logic                  done,
    output logic [OPER_WIDTH-1:0] quotient,
    output logic [OPER_WIDTH-1:0] remainder
);
    logic [OPER_WIDTH-1:0] quo_reg, quo_next;
    logic [OPER_WIDTH-1:0] rem_reg, rem_next;
    logic [OPER_WIDTH-1:0] den_reg, den_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [OPER_WIDTH:0]   trial;

    // one shift-subtract step per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[OPER_WIDTH-1]} - {1'b0, den_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor_in;
            cnt_next  = CNT_WIDTH'(OPER_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[OPER_WIDTH]) begin
                rem_next = trial[OPER_WIDTH-1:0];
                quo_next = {quo_reg[OPER_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[OPER_WIDTH-2:0], quo_reg[OPER_WIDTH-1]};
                quo_next = {quo_reg[OPER_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ===== design/extended_gcd_top.sv =====
// per Euclid step: a check state, the serial divider and two bit-serial
// multiply-subtract passes (ST_MULX for coeff_a, ST_MULY for coeff_b)
// one word at a time; a new word is accepted as soon as the engine is idle,
// while the previous result may still wait in the output register
// the serial divider and the bit-serial multiply-subtract set the step time
// aresetn (synchronous, active low) clears control; data registers are not reset
// ----------------------------------------------------------------------------
// extended_gcd_top
// extended euclidean algorithm with bit-serial division and coefficient update
// ----------------------------------------------------------------------------
module extended_gcd_top
    import egcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_BYTES*8-1:0]  s_tdata,  // value_a, value_b
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_BYTES*8-1:0] m_tdata   // divisor, coeff_a, coeff_b
);
    egcd_state_t state_reg, state_next;
    logic        div_start;
    logic        div_done;

    logic [OPER_WIDTH-1:0] pr_reg, pr_next, cr_reg, cr_next;
    logic [DATA_WIDTH-1:0] px_reg, px_next, cx_reg, cx_next;
    logic [DATA_WIDTH-1:0] py_reg, py_next, cy_reg, cy_next;
    logic [OPER_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next, mc_reg, mc_next;
    logic [CNT_WIDTH-1:0]  bit_reg, bit_next;
    logic                  ov_reg, ov_next;
    logic [OUT_BYTES*8-1:0] out_reg, out_next;
    logic [OPER_WIDTH-1:0] quo, rem;

    egcd_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .dividend   (pr_reg),
        .divisor_in (cr_reg),
        .done       (div_done),
        .quotient   (quo),
        .remainder  (rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid && s_tready) state_next = ST_CHECK;
            ST_CHECK: state_next = (cr_reg == '0) ? ST_DONE : ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MULX;
            ST_MULX:  if (bit_reg == CNT_WIDTH'(OPER_WIDTH - 1)) state_next = ST_MULY;
            ST_MULY:  if (bit_reg == CNT_WIDTH'(OPER_WIDTH - 1)) state_next = ST_CHECK;
            ST_DONE:  if (!ov_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        pr_next = pr_reg; cr_next = cr_reg;
        px_next = px_reg; cx_next = cx_reg;
        py_next = py_reg; cy_next = cy_reg;
        q_next = q_reg; acc_next = acc_reg; mc_next = mc_reg;
        bit_next = bit_reg;
        ov_next = ov_reg;
        out_next = out_reg;
        div_start = 1'b0;
        s_tready = (state_reg == ST_IDLE);
        if (ov_reg && m_tready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    pr_next = s_tdata[OPER_WIDTH-1:0];
                    cr_next = s_tdata[2*OPER_WIDTH-1:OPER_WIDTH];
                    px_next = DATA_WIDTH'(1); cx_next = '0;
                    py_next = '0;             cy_next = DATA_WIDTH'(1);
                end
            end
            ST_CHECK: begin
                if (cr_reg != '0) div_start = 1'b1;
            end
            ST_DIV: begin
                if (div_done) begin
                    q_next   = quo;
                    pr_next  = cr_reg;
                    cr_next  = rem;
                    acc_next = px_reg;
                    mc_next  = cx_reg;
                    bit_next = '0;
                end
            end
            ST_MULX, ST_MULY: begin
                // one quotient bit per cycle: acc -= q_bit * (mc << bit)
                if (q_reg[0]) acc_next = acc_reg - mc_reg;
                mc_next  = {mc_reg[DATA_WIDTH-2:0], 1'b0};
                q_next   = {q_reg[0], q_reg[OPER_WIDTH-1:1]};
                bit_next = bit_reg + 1'b1;
                if (bit_reg == CNT_WIDTH'(OPER_WIDTH - 1)) begin
                    bit_next = '0;
                    if (state_reg == ST_MULX) begin
                        px_next  = cx_reg;
                        cx_next  = acc_next;
                        acc_next = py_reg;
                        mc_next  = cy_reg;
                    end else begin
                        py_next = cy_reg;
                        cy_next = acc_next;
                    end
                end
            end
            ST_DONE: begin
                if (!ov_reg) begin
                    out_next = {{(OUT_BYTES*8-OPER_WIDTH-2*DATA_WIDTH){1'b0}},
                                py_reg, px_reg, pr_reg};
                    ov_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            bit_reg   <= bit_next;
        end
        pr_reg <= pr_next; cr_reg <= cr_next;
        px_reg <= px_next; cx_reg <= cx_next;
        py_reg <= py_next; cy_reg <= cy_next;
        q_reg <= q_next; acc_reg <= acc_next; mc_reg <= mc_next;
        out_reg <= out_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;
endmodule

// ===== design/egcd_checker.sv =====
// ----------------------------------------------------------------------------
// egcd_checker
// port-level checks of the extended gcd block
// ----------------------------------------------------------------------------
`include "extended_gcd_top_assert.svh"
module egcd_checker
    import egcd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_BYTES*8-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_BYTES*8-1:0] m_tdata
);
    // a result waits while stalled
    `EG_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a fresh result leaves the engine free for the next word
    `EG_ASSERT_IMP(a_rdy, aclk, aresetn, $rose(m_tvalid), s_tready)
    // an accepted word is not answered in the next cycle
    `EG_ASSERT_NEXT(a_lat, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid) && !s_tready)
endmodule

bind extended_gcd_top egcd_checker u_egcd_checker (.*);

// ===== sim/extended_gcd_top_tb.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_top_tb
// drives operand pairs into the extended gcd block, predicts gcd and bezout
// coefficients per pair, and checks every result word in order
// ----------------------------------------------------------------------------
module extended_gcd_top_tb;
    import egcd_pkg::*;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] coeff_b;
        logic [DATA_WIDTH-1:0] coeff_a;
        logic [OPER_WIDTH-1:0] divisor;
    } gcd_result_t;

    // scoreboard of predicted gcd results
    class gcd_scoreboard;
        gcd_result_t pending[$];
        int errors = 0;

        function void note_operands(logic [OPER_WIDTH-1:0] a, logic [OPER_WIDTH-1:0] b);
            logic [63:0] pr, cr, px, cx, py, cy, q, t;
            gcd_result_t r;
            pr = {1'b0, a};
            cr = {1'b0, b};
            px = 64'd1; cx = 64'd0;
            py = 64'd0; cy = 64'd1;
            while (cr != 0) begin
                q = pr / cr;
                t = cr; cr = pr - q * cr; pr = t;
                t = cx; cx = px - q * cx; px = t;
                t = cy; cy = py - q * cy; py = t;
            end
            r.divisor = pr[OPER_WIDTH-1:0];
            r.coeff_a = px;
            r.coeff_b = py;
            pending.push_back(r);
        endfunction

        function void check_result(gcd_result_t got);
            gcd_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.divisor !== exp_r.divisor) begin
                $display("%0t: divisor exp %h got %h", $time, exp_r.divisor, got.divisor);
                errors++;
            end
            if (got.coeff_a !== exp_r.coeff_a) begin
                $display("%0t: coeff_a exp %h got %h", $time, exp_r.coeff_a, got.coeff_a);
                errors++;
            end
            if (got.coeff_b !== exp_r.coeff_b) begin
                $display("%0t: coeff_b exp %h got %h", $time, exp_r.coeff_b, got.coeff_b);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 200000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_BYTES*8-1:0]  s_tdata;   // value_a, value_b
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_BYTES*8-1:0] m_tdata;   // divisor, coeff_a, coeff_b

    gcd_scoreboard gcd_sb;
    bit stim_done;
    int idle_cycles;
    bit hold_off;

    extended_gcd_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // random operand with varied magnitude
    function automatic logic [OPER_WIDTH-1:0] rand_operand();
        logic [63:0] v;
        int sh;
        v = {$urandom, $urandom};
        sh = $urandom_range(0, 62);
        case ($urandom_range(0, 5))
            0: v = v >> 62;
            1: v = v >> sh;
            2: v = 64'h7fff_ffff_ffff_ffff - (v >> 50);
            default: v = v >> 1;
        endcase
        return v[OPER_WIDTH-1:0];
    endfunction

    // offer one word and wait for acceptance
    task automatic send_word(logic [OPER_WIDTH-1:0] a, logic [OPER_WIDTH-1:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_BYTES*8-2*OPER_WIDTH){1'b0}}, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gcd_sb.note_operands(a, b);
    endtask

    // send one word then maybe drop valid for a gap
    task automatic send_pair(logic [OPER_WIDTH-1:0] a, logic [OPER_WIDTH-1:0] b,
                             inout int burst);
        int gap;
        send_word(a, b);
        burst--;
        if (burst <= 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst = $urandom_range(1, 6);
        end
    endtask

    // stimulus
    initial begin
        logic [OPER_WIDTH-1:0] mx;
        logic [OPER_WIDTH-1:0] g;
        int burst;
        gcd_sb = new();
        mx = '1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        stim_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst = 4;
        // directed corners: zeros, ones, extremes, consecutive fibonacci
        send_pair(0, 0, burst);
        send_pair(5, 0, burst);
        send_pair(0, 9, burst);
        send_pair(mx, 0, burst);
        send_pair(0, mx, burst);
        send_pair(1, 1, burst);
        send_pair(mx, mx, burst);
        send_pair(mx, 1, burst);
        send_pair(1, mx, burst);
        send_pair(mx, mx - 1, burst);
        send_pair(240, 46, burst);
        send_pair(46, 240, burst);
        send_pair(63'd7540113804746346429, 63'd4660046610375530309, burst);
        send_pair(63'd4660046610375530309, 63'd2880067194370816120, burst);
        send_pair(63'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaaa, burst);
        send_pair(63'h4000_0000_0000_0000, 63'h2000_0000_0000_0000, burst);
        // random pairs, some with a large common factor
        for (int i = 0; i < 100; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                g = OPER_WIDTH'($urandom_range(2, 100000));
                send_pair((rand_operand() >> 20) * g, (rand_operand() >> 20) * g, burst);
            end else begin
                send_pair(rand_operand(), rand_operand(), burst);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // long receiver hold-off so the block stalls its input
    initial begin
        hold_off = 1'b0;
        repeat (300) @(posedge aclk);
        hold_off = 1'b1;
        repeat (30000) @(posedge aclk);
        hold_off = 1'b0;
    end

    // receiver ready pattern
    initial begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if (hold_off)
                m_tready <= 1'b0;
            else if ((phase / 500) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // result check and watchdog
    initial begin
        gcd_result_t got;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[OPER_WIDTH+2*DATA_WIDTH-1:0];
                gcd_sb.check_result(got);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("extended_gcd_top_tb NOT OK");
                $finish;
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (gcd_sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (gcd_sb.errors == 0)
            $display("extended_gcd_top_tb OK");
        else
            $display("extended_gcd_top_tb NOT OK");
        $finish;
    end
endmodule

// ===== extended_gcd_top.f =====
+incdir+design
design/egcd_pkg.sv
design/egcd_div.sv
design/extended_gcd_top.sv
design/egcd_checker.sv
sim/extended_gcd_top_tb.sv
